// File: design/wcte_pkg.sv
// Package: shared types and codes for the waypoint cross-track error unit.
`default_nettype none
package wcte_pkg;

  // Request codes of an input word
  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_SAMPLE = 2'd2,
    REQ_UNUSED = 2'd3
  } req_t;

  // Status codes of a result word
  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FEW      = 2'd1,
    STAT_ZERO_LEN = 2'd2,
    STAT_FULL     = 2'd3
  } status_t;

  // Datapath operations, one per cycle while the datapath is not busy
  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD_IN,
    DP_LOAD_S,
    DP_LOAD_E,
    DP_LOAD_N,
    DP_SHIFT_SE,
    DP_MUL,
    DP_SQRT,
    DP_ABS,
    DP_DIV
  } dp_op_t;

  // Product terms; the first of each pair clears the accumulator
  typedef enum logic [2:0] {
    MS_DOT1,
    MS_DOT2,
    MS_LEFT1,
    MS_LEFT2,
    MS_LEN1,
    MS_LEN2,
    MS_ERR1,
    MS_ERR2
  } mul_sel_t;

  typedef struct packed {
    dp_op_t   op;
    mul_sel_t sel;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
    logic acc_pos;
    logic acc_zero;
  } dp_stat_t;

  typedef struct packed {
    logic    load;
    status_t status;
    logic    done;
    logic    left;
  } out_cmd_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RD_E,
    S_CHK,
    S_DOT1,
    S_DOT1W,
    S_DOT2,
    S_DOT2W,
    S_DEC,
    S_AFTER,
    S_LDN,
    S_LEFT1,
    S_LEFT1W,
    S_LEFT2,
    S_LEFT2W,
    S_LEFTD,
    S_LEN1,
    S_LEN1W,
    S_LEN2,
    S_LEN2W,
    S_LENC,
    S_SQRTW,
    S_ERR1,
    S_ERR1W,
    S_ERR2,
    S_ERR2W,
    S_ABS,
    S_DIV,
    S_DIVW,
    S_OUT
  } ctrl_state_t;

endpackage
`default_nettype wire

// File: design/wcte_in_if.sv
// Interface: request channel (clear, append, position sample).
`default_nettype none
interface wcte_in_if #(
  parameter int COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    req_type;
  logic signed [COORD_WIDTH-1:0] pos_x;
  logic signed [COORD_WIDTH-1:0] pos_y;

  modport source(output valid, req_type, pos_x, pos_y, input ready);
  modport sink(input valid, req_type, pos_x, pos_y, output ready);
endinterface
`default_nettype wire

// File: design/wcte_out_if.sv
// Interface: result channel.
`default_nettype none
interface wcte_out_if #(
  parameter int COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] signed_error;
  logic                          path_done;
  logic                          next_turns_left;
  logic [1:0]                    status;

  modport source(output valid, signed_error, path_done, next_turns_left, status,
                 input ready);
  modport sink(input valid, signed_error, path_done, next_turns_left, status,
               output ready);
endinterface
`default_nettype wire

// File: design/wcte_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module wcte_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: design/wcte_dp.sv
// Datapath: waypoint registers, bit-serial multiply-accumulate, root and divider.
`default_nettype none
module wcte_dp #(
  parameter int COORD_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire wcte_pkg::dp_cmd_t             cmd,
  input  wire logic signed [COORD_WIDTH-1:0] px_in,
  input  wire logic signed [COORD_WIDTH-1:0] py_in,
  input  wire logic [2*COORD_WIDTH-1:0]      rdata,
  output wcte_pkg::dp_stat_t                 stat,
  output logic signed [COORD_WIDTH-1:0]      err
);
  import wcte_pkg::*;

  localparam int W   = COORD_WIDTH;
  localparam int DW  = W + 1;       // difference of two coordinates
  localparam int PW  = 2 * W;       // product of two magnitudes
  localparam int AW  = 2 * W + 2;   // accumulator, radicand, dividend
  localparam int RW  = W + 4;       // partial remainder
  localparam int CTW = $clog2(2 * W + 3);

  typedef enum logic [1:0] {M_IDLE, M_MUL, M_SQRT, M_DIV} mode_t;

  mode_t                mode;
  logic signed [W-1:0]  px, py, sx, sy, ex, ey, nx, ny;
  logic [PW-1:0]        mcand, prod;
  logic [W-1:0]         mplier;
  logic                 mneg, msub, is_left;
  logic [CTW-1:0]       cnt;
  logic [AW-1:0]        acc;
  logic [RW-1:0]        rem;
  logic [W:0]           root;

  // coordinate differences, one bit wider than a coordinate
  function automatic logic signed [DW-1:0] diff(logic signed [W-1:0] a,
                                                logic signed [W-1:0] b);
    return $signed({a[W-1], a}) - $signed({b[W-1], b});
  endfunction

  logic signed [DW-1:0] dx, dy, pxe, pye, nsx, nsy, psx, psy;
  assign dx  = diff(ex, sx);
  assign dy  = diff(ey, sy);
  assign pxe = diff(px, ex);
  assign pye = diff(py, ey);
  assign nsx = diff(nx, sx);
  assign nsy = diff(ny, sy);
  assign psx = diff(px, sx);
  assign psy = diff(py, sy);

  // operand selection for the multiplier
  logic signed [DW-1:0] op_a, op_b;
  logic                 op_sub, op_clr;
  always_comb begin
    op_a   = dx;
    op_b   = dx;
    op_sub = 1'b0;
    op_clr = 1'b0;
    case (cmd.sel)
      MS_DOT1:  begin op_a = pxe; op_b = dx;  op_clr = 1'b1; end
      MS_DOT2:  begin op_a = pye; op_b = dy;  end
      MS_LEFT1: begin op_a = dx;  op_b = nsy; op_clr = 1'b1; end
      MS_LEFT2: begin op_a = dy;  op_b = nsx; op_sub = 1'b1; end
      MS_LEN1:  begin op_a = dx;  op_b = dx;  op_clr = 1'b1; end
      MS_LEN2:  begin op_a = dy;  op_b = dy;  end
      MS_ERR1:  begin op_a = dx;  op_b = psy; op_clr = 1'b1; end
      MS_ERR2:  begin op_a = dy;  op_b = psx; op_sub = 1'b1; end
      default:  begin op_a = dx;  op_b = dx;  end
    endcase
  end

  logic [DW-1:0] a_abs, b_abs;
  assign a_abs = op_a[DW-1] ? (~op_a + DW'(1)) : op_a;
  assign b_abs = op_b[DW-1] ? (~op_b + DW'(1)) : op_b;

  // accumulate step at the end of a product
  logic [AW-1:0] p_ext, acc_mac;
  assign p_ext   = AW'(prod);
  assign acc_mac = (mneg ^ msub) ? (acc - p_ext) : (acc + p_ext);

  // root step: two radicand bits a cycle
  logic [RW-1:0] sq_rem, sq_trial;
  assign sq_rem   = {rem[RW-3:0], acc[AW-1:AW-2]};
  assign sq_trial = RW'({root, 2'b01});

  // divide step: one dividend bit a cycle, quotient shifts into acc
  logic [RW-1:0] dv_rem, dv_den;
  assign dv_rem = {rem[RW-2:0], acc[AW-1]};
  assign dv_den = RW'(root);

  // saturation of the quotient and sign
  logic [AW-1:0] lim, q_sat;
  logic [W-1:0]  q_low;
  assign lim   = (AW'(1) << (W - 1)) - AW'(!is_left);
  assign q_sat = (acc > lim) ? lim : acc;
  assign q_low = q_sat[W-1:0];
  assign err   = is_left ? $signed(~q_low + W'(1)) : $signed(q_low);

  assign stat.busy     = (mode != M_IDLE);
  assign stat.acc_zero = (acc == '0);
  assign stat.acc_pos  = !acc[AW-1] && (acc != '0);

  // unit mode
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
    end else begin
      case (mode)
        M_IDLE: begin
          if (cmd.op == DP_MUL) mode <= M_MUL;
          else if (cmd.op == DP_SQRT) mode <= M_SQRT;
          else if (cmd.op == DP_DIV) mode <= M_DIV;
        end
        M_MUL:   if (cnt == '0) mode <= M_IDLE;
        default: if (cnt == CTW'(1)) mode <= M_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (mode)
      M_MUL: begin
        if (cnt == '0) begin
          acc <= acc_mac;
        end else begin
          if (mplier[0]) prod <= prod + mcand;
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          cnt    <= cnt - CTW'(1);
        end
      end
      M_SQRT: begin
        if (sq_rem >= sq_trial) begin
          rem  <= sq_rem - sq_trial;
          root <= {root[W-1:0], 1'b1};
        end else begin
          rem  <= sq_rem;
          root <= {root[W-1:0], 1'b0};
        end
        acc <= acc << 2;
        cnt <= cnt - CTW'(1);
      end
      M_DIV: begin
        if (dv_rem >= dv_den) begin
          rem <= dv_rem - dv_den;
          acc <= {acc[AW-2:0], 1'b1};
        end else begin
          rem <= dv_rem;
          acc <= {acc[AW-2:0], 1'b0};
        end
        cnt <= cnt - CTW'(1);
      end
      default: begin
        case (cmd.op)
          DP_LOAD_IN:  begin px <= px_in; py <= py_in; end
          DP_LOAD_S:   begin sx <= rdata[2*W-1:W]; sy <= rdata[W-1:0]; end
          DP_LOAD_E:   begin ex <= rdata[2*W-1:W]; ey <= rdata[W-1:0]; end
          DP_LOAD_N:   begin nx <= rdata[2*W-1:W]; ny <= rdata[W-1:0]; end
          DP_SHIFT_SE: begin sx <= ex; sy <= ey; end
          DP_MUL: begin
            mcand  <= PW'(a_abs[W-1:0]);
            mplier <= b_abs[W-1:0];
            prod   <= '0;
            mneg   <= op_a[DW-1] ^ op_b[DW-1];
            msub   <= op_sub;
            cnt    <= CTW'(W);
            if (op_clr) acc <= '0;
          end
          DP_SQRT: begin
            rem  <= '0;
            root <= '0;
            cnt  <= CTW'(W + 1);
          end
          DP_ABS: begin
            is_left <= stat.acc_pos;
            if (acc[AW-1]) acc <= ~acc + AW'(1);
          end
          DP_DIV: begin
            rem <= '0;
            cnt <= CTW'(AW);
          end
          default: ;
        endcase
      end
    endcase
  end
endmodule
`default_nettype wire

// File: design/wcte_ctrl.sv
// Controller: waypoint count, current segment and the sequence of datapath steps.
`default_nettype none
module wcte_ctrl #(
  parameter int MAX_WAYPOINTS = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  input  wire logic [1:0]                       req_type,
  output logic                                  in_ready,
  input  wire logic                             out_hold,
  input  wire wcte_pkg::dp_stat_t               dps,
  output wcte_pkg::dp_cmd_t                     cmd,
  output wcte_pkg::out_cmd_t                    oc,
  output logic                                  ram_we,
  output logic [$clog2(MAX_WAYPOINTS)-1:0]      waddr,
  output logic [$clog2(MAX_WAYPOINTS)-1:0]      raddr
);
  import wcte_pkg::*;

  localparam int IW   = $clog2(MAX_WAYPOINTS);
  localparam int CNTW = $clog2(MAX_WAYPOINTS + 1);
  localparam int EW   = CNTW + 1;

  ctrl_state_t     state, state_next;
  logic [CNTW-1:0] count, count_next;
  logic [IW-1:0]   seg, seg_next;
  status_t         stat, stat_next;
  logic            done, done_next, left, left_next;

  logic [EW-1:0] seg_ext, seg_plus2, count_ext;
  logic          last_seg;
  assign seg_ext   = EW'(seg);
  assign seg_plus2 = seg_ext + EW'(2);
  assign count_ext = EW'(count);
  assign last_seg  = (seg_plus2 >= count_ext);

  assign waddr  = count[IW-1:0];

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      seg   <= '0;
      stat  <= STAT_OK;
      done  <= 1'b0;
      left  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      seg   <= seg_next;
      stat  <= stat_next;
      done  <= done_next;
      left  <= left_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    count_next = count;
    seg_next   = seg;
    stat_next  = stat;
    done_next  = done;
    left_next  = left;
    in_ready   = 1'b0;
    ram_we     = 1'b0;
    raddr      = seg;
    cmd.op     = DP_NOP;
    cmd.sel    = MS_DOT1;
    oc.load    = 1'b0;
    oc.status  = stat;
    oc.done    = done;
    oc.left    = left;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (req_t'(req_type))
            REQ_CLEAR: begin
              count_next = '0;
              seg_next   = '0;
            end
            REQ_APPEND: begin
              if (count == CNTW'(MAX_WAYPOINTS)) begin
                stat_next  = STAT_FULL;
                done_next  = 1'b0;
                left_next  = 1'b0;
                state_next = S_OUT;
              end else begin
                ram_we     = 1'b1;
                count_next = count + CNTW'(1);
              end
            end
            REQ_SAMPLE: begin
              cmd.op = DP_LOAD_IN;
              if (count < CNTW'(2)) begin
                stat_next  = STAT_FEW;
                done_next  = 1'b1;
                left_next  = 1'b1;
                state_next = S_OUT;
              end else begin
                if (seg_plus2 > count_ext) seg_next = '0;
                raddr      = seg_next;
                stat_next  = STAT_OK;
                state_next = S_RD_E;
              end
            end
            REQ_UNUSED: ;
          endcase
        end
      end
      S_RD_E: begin
        cmd.op     = DP_LOAD_S;
        raddr      = seg + IW'(1);
        state_next = S_CHK;
      end
      S_CHK: begin
        cmd.op     = DP_LOAD_E;
        state_next = last_seg ? S_AFTER : S_DOT1;
      end
      S_DOT1:  begin cmd.op = DP_MUL; cmd.sel = MS_DOT1; state_next = S_DOT1W; end
      S_DOT1W: if (!dps.busy) state_next = S_DOT2;
      S_DOT2:  begin cmd.op = DP_MUL; cmd.sel = MS_DOT2; state_next = S_DOT2W; end
      S_DOT2W: if (!dps.busy) state_next = S_DEC;
      // step forward when the position has passed the segment end
      S_DEC: begin
        if (dps.acc_pos) begin
          cmd.op     = DP_SHIFT_SE;
          seg_next   = seg + IW'(1);
          raddr      = seg + IW'(2);
          state_next = S_CHK;
        end else begin
          state_next = S_AFTER;
        end
      end
      S_AFTER: begin
        if (last_seg) begin
          done_next  = 1'b1;
          left_next  = 1'b1;
          state_next = S_LEN1;
        end else begin
          done_next  = 1'b0;
          raddr      = seg + IW'(2);
          state_next = S_LDN;
        end
      end
      S_LDN:    begin cmd.op = DP_LOAD_N; state_next = S_LEFT1; end
      S_LEFT1:  begin cmd.op = DP_MUL; cmd.sel = MS_LEFT1; state_next = S_LEFT1W; end
      S_LEFT1W: if (!dps.busy) state_next = S_LEFT2;
      S_LEFT2:  begin cmd.op = DP_MUL; cmd.sel = MS_LEFT2; state_next = S_LEFT2W; end
      S_LEFT2W: if (!dps.busy) state_next = S_LEFTD;
      S_LEFTD:  begin left_next = dps.acc_pos; state_next = S_LEN1; end
      S_LEN1:   begin cmd.op = DP_MUL; cmd.sel = MS_LEN1; state_next = S_LEN1W; end
      S_LEN1W:  if (!dps.busy) state_next = S_LEN2;
      S_LEN2:   begin cmd.op = DP_MUL; cmd.sel = MS_LEN2; state_next = S_LEN2W; end
      S_LEN2W:  if (!dps.busy) state_next = S_LENC;
      // zero-length segment ends here with no distance
      S_LENC: begin
        if (dps.acc_zero) begin
          stat_next  = STAT_ZERO_LEN;
          state_next = S_OUT;
        end else begin
          cmd.op     = DP_SQRT;
          state_next = S_SQRTW;
        end
      end
      S_SQRTW: if (!dps.busy) state_next = S_ERR1;
      S_ERR1:  begin cmd.op = DP_MUL; cmd.sel = MS_ERR1; state_next = S_ERR1W; end
      S_ERR1W: if (!dps.busy) state_next = S_ERR2;
      S_ERR2:  begin cmd.op = DP_MUL; cmd.sel = MS_ERR2; state_next = S_ERR2W; end
      S_ERR2W: if (!dps.busy) state_next = S_ABS;
      S_ABS:   begin cmd.op = DP_ABS; state_next = S_DIV; end
      S_DIV:   begin cmd.op = DP_DIV; state_next = S_DIVW; end
      S_DIVW:  if (!dps.busy) state_next = S_OUT;
      S_OUT: begin
        if (!out_hold) begin
          oc.load    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// File: design/waypoint_cross_track_error_unit.sv
// Top level: waypoint cross-track error unit with its output register.
//
//   channel  dir  fields
//   req      in   req_type[1:0], pos_x[W-1:0], pos_y[W-1:0]
//   rsp      out  signed_error[W-1:0], path_done, next_turns_left, status[1:0]
//
// A sample runs the bit-serial multiplier for each product, then the root
// and the divider, and steps forward over each segment that it has passed;
// a zero-length segment stops after its length.
// Synchronous reset empties the path; the table contents stay undefined.
// A result waits in the output register; a new word is taken meanwhile, and
// the next result waits until the held one is taken.
`default_nettype none
module waypoint_cross_track_error_unit #(
  parameter int MAX_WAYPOINTS = 64,
  parameter int COORD_WIDTH   = 32
) (
  input wire logic   clk,
  input wire logic   rst,
  wcte_in_if.sink    req,
  wcte_out_if.source rsp
);
  import wcte_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int IW = $clog2(MAX_WAYPOINTS);

  dp_cmd_t             cmd;
  dp_stat_t            dps;
  out_cmd_t            oc;
  logic                ram_we, out_hold;
  logic [IW-1:0]       waddr, raddr;
  logic [2*W-1:0]      rdata;
  logic signed [W-1:0] err;

  assign out_hold = rsp.valid && !rsp.ready;

  wcte_ctrl #(.MAX_WAYPOINTS(MAX_WAYPOINTS)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .req_type (req.req_type),
    .in_ready (req.ready),
    .out_hold (out_hold),
    .dps      (dps),
    .cmd      (cmd),
    .oc       (oc),
    .ram_we   (ram_we),
    .waddr    (waddr),
    .raddr    (raddr)
  );

  wcte_ram #(.WIDTH(2 * W), .DEPTH(MAX_WAYPOINTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata ({req.pos_x, req.pos_y}),
    .raddr (raddr),
    .rdata (rdata)
  );

  wcte_dp #(.COORD_WIDTH(W)) u_dp (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .px_in (req.pos_x),
    .py_in (req.pos_y),
    .rdata (rdata),
    .stat  (dps),
    .err   (err)
  );

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (oc.load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  // output register payload; distance only for a good sample
  always_ff @(posedge clk) begin
    if (oc.load) begin
      rsp.signed_error    <= (oc.status == STAT_OK) ? err : '0;
      rsp.path_done       <= oc.done;
      rsp.next_turns_left <= oc.left;
      rsp.status          <= oc.status;
    end
  end
endmodule
`default_nettype wire

// File: tb/wcte_checker.sv
// Checker: watches both channels, predicts each result and compares it.
`timescale 1ns / 1ps
`default_nettype none
module wcte_checker (
  input wire logic clk,
  input wire logic rst,
  wcte_in_if       req_ch,
  wcte_out_if      rsp_ch,
  output int       fail_count,
  output int       pending
);
  import wcte_pkg::*;

  localparam int QDEPTH = 64;

  typedef struct {
    logic signed [31:0] err;
    logic               done;
    logic               left;
    status_t            st;
  } track_result_t;

  // Path table and current segment as the block should hold them
  logic signed [127:0] path_x [64];
  logic signed [127:0] path_y [64];
  int                  path_len;
  int                  seg_idx;

  // Ring of predicted results, oldest at exp_rd
  track_result_t       expected_results [QDEPTH];
  int                  exp_wr = 0;
  int                  exp_rd = 0;

  assign pending = exp_wr - exp_rd;

  function automatic logic [63:0] root_floor(input logic [127:0] v);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = 62; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (({64'd0, t} * {64'd0, t}) <= v) r = t;
    end
    return r;
  endfunction

  task automatic add_expected(input track_result_t r);
    expected_results[exp_wr % QDEPTH] = r;
    exp_wr++;
  endtask

  // Advance the path model by one accepted word; queue any result it causes
  task automatic track_word(input logic [1:0] rq, input logic signed [31:0] x,
                            input logic signed [31:0] y);
    logic signed [127:0] px, py, sx, sy, ex, ey, dx, dy, dot, cr, len2;
    logic [127:0]        mag, q, lim;
    logic [63:0]         root;
    logic                is_left;
    track_result_t       r;
    int                  s;
    px = x;
    py = y;
    r = '{err: '0, done: 1'b0, left: 1'b0, st: STAT_OK};
    case (req_t'(rq))
      REQ_CLEAR: begin
        path_len = 0;
        seg_idx  = 0;
      end
      REQ_APPEND: begin
        if (path_len >= 64) begin
          r.st = STAT_FULL;
          add_expected(r);
        end else begin
          path_x[path_len] = px;
          path_y[path_len] = py;
          path_len++;
        end
      end
      REQ_SAMPLE: begin
        if (path_len < 2) begin
          r.done = 1'b1;
          r.left = 1'b1;
          r.st   = STAT_FEW;
        end else begin
          if (seg_idx + 2 > path_len) seg_idx = 0;
          // step forward while the position is past the segment end
          forever begin
            s  = seg_idx;
            sx = path_x[s];
            sy = path_y[s];
            ex = path_x[s+1];
            ey = path_y[s+1];
            if (s + 2 >= path_len) break;
            dot = (px - ex) * (ex - sx) + (py - ey) * (ey - sy);
            if (dot <= 0) break;
            seg_idx = s + 1;
          end
          dx     = ex - sx;
          dy     = ey - sy;
          r.done = (s + 2 >= path_len);
          if (r.done) r.left = 1'b1;
          else r.left = (dx * (path_y[s+2] - sy) - dy * (path_x[s+2] - sx)) > 0;
          len2 = dx * dx + dy * dy;
          if (len2 == 0) begin
            r.st = STAT_ZERO_LEN;
          end else begin
            cr      = dx * (py - sy) - dy * (px - sx);
            is_left = cr > 0;
            mag     = (cr < 0) ? -cr : cr;
            root    = root_floor(len2);
            q       = mag / {64'd0, root};
            lim     = is_left ? 128'h8000_0000 : 128'h7FFF_FFFF;
            if (q > lim) q = lim;
            r.err   = is_left ? -q[31:0] : q[31:0];
          end
        end
        add_expected(r);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      path_len   <= 0;
      seg_idx    <= 0;
      fail_count <= 0;
      exp_wr = 0;
      exp_rd = 0;
    end else begin
      // response side first: a result never leaves in the cycle its word enters
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (exp_wr == exp_rd) begin
          $error("result word with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          track_result_t e;
          e = expected_results[exp_rd % QDEPTH];
          exp_rd++;
          if (rsp_ch.signed_error !== e.err || rsp_ch.path_done !== e.done ||
              rsp_ch.next_turns_left !== e.left || rsp_ch.status !== e.st) begin
            fail_count <= fail_count + 1;
            if (rsp_ch.signed_error !== e.err)
              $error("signed_error: expected %0d, got %0d", e.err, rsp_ch.signed_error);
            if (rsp_ch.path_done !== e.done)
              $error("path_done: expected %0d, got %0d", e.done, rsp_ch.path_done);
            if (rsp_ch.next_turns_left !== e.left)
              $error("next_turns_left: expected %0d, got %0d", e.left,
                     rsp_ch.next_turns_left);
            if (rsp_ch.status !== e.st)
              $error("status: expected %0d, got %0d", e.st, rsp_ch.status);
          end
        end
      end
      if (req_ch.valid && req_ch.ready)
        track_word(req_ch.req_type, req_ch.pos_x, req_ch.pos_y);
    end
  end

endmodule
`default_nettype wire

// File: tb/tb_waypoint_cross_track_error_unit.sv
// Testbench top: drives path and position words, stalls the result side, gives the verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb_waypoint_cross_track_error_unit;
  import wcte_pkg::*;

  localparam int CYCLE_LIMIT = 60_000_000;
  localparam int ITEM_TARGET = 1650;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending;
  int   cycles = 0;
  int   burst_left = 0;
  int   words_sent = 0;
  int   stall_mode = 0;
  int   stall_span = 0;

  // Waypoints the block currently holds, for aiming samples near the path
  logic signed [31:0] plan_x [64];
  logic signed [31:0] plan_y [64];
  int                 plan_len = 0;

  wcte_in_if  req_ch ();
  wcte_out_if rsp_ch ();

  waypoint_cross_track_error_unit uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  wcte_checker chk (
    .clk(clk),
    .rst(rst),
    .req_ch(req_ch),
    .rsp_ch(rsp_ch),
    .fail_count(fail_count),
    .pending(pending)
  );

  always #5 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL waypoint_cross_track_error_unit");
      $finish;
    end
  end

  // Result side: changes between always-ready, random and long-stall patterns
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (stall_span == 0) begin
        stall_mode <= $urandom_range(0, 2);
        stall_span <= $urandom_range(5, 200);
      end else begin
        stall_span <= stall_span - 1;
      end
      case (stall_mode)
        0: rsp_ch.ready <= 1'b1;
        1: rsp_ch.ready <= $urandom_range(0, 1);
        default: rsp_ch.ready <= ($urandom_range(0, 15) == 0);
      endcase
    end
  end

  // One word on the request channel, in bursts with random gaps
  task automatic send(input req_t rq, input logic signed [31:0] x,
                      input logic signed [31:0] y);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= rq;
    req_ch.pos_x    <= x;
    req_ch.pos_y    <= y;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    burst_left--;
    if (rq != REQ_UNUSED) words_sent++;
    if (rq == REQ_CLEAR) begin
      plan_len = 0;
    end else if (rq == REQ_APPEND && plan_len < 64) begin
      plan_x[plan_len] = x;
      plan_y[plan_len] = y;
      plan_len++;
    end
  endtask

  function automatic logic signed [31:0] near(input logic signed [31:0] c, input int spread);
    return c + $signed($urandom_range(0, 2 * spread)) - spread;
  endfunction

  initial begin
    int n, k, spread, w;
    logic signed [31:0] x, y;
    logic full_range;
    req_ch.valid    = 1'b0;
    req_ch.req_type = REQ_CLEAR;
    req_ch.pos_x    = '0;
    req_ch.pos_y    = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty and single-point paths, unused code, zero-length segment
    send(REQ_SAMPLE, 32'sd0, 32'sd0);
    send(REQ_APPEND, 32'sd100, -32'sd100);
    send(REQ_SAMPLE, 32'sd5, 32'sd5);
    send(REQ_UNUSED, -32'sd1, -32'sd1);
    send(REQ_APPEND, 32'sd100, -32'sd100);
    send(REQ_APPEND, 32'sd9000, 32'sd70);
    send(REQ_SAMPLE, -32'sd7, 32'sd3);
    send(REQ_CLEAR, 32'sd0, 32'sd0);
    // Extreme corners: saturation both ways, left turn and right turn
    send(REQ_APPEND, 32'h8000_0000, 32'h8000_0000);
    send(REQ_APPEND, 32'h7FFF_FFFF, 32'h8000_0000);
    send(REQ_APPEND, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send(REQ_SAMPLE, 32'h8000_0000, 32'h7FFF_FFFF);
    send(REQ_SAMPLE, 32'h0000_0000, 32'h8000_0000);
    send(REQ_SAMPLE, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send(REQ_SAMPLE, 32'hFFFF_FFFF, 32'h8000_0001);
    send(REQ_CLEAR, 32'sd0, 32'sd0);
    send(REQ_APPEND, 32'h7FFF_FFFF, 32'sd0);
    send(REQ_APPEND, 32'h8000_0000, 32'sd0);
    send(REQ_APPEND, 32'h8000_0000, 32'h7FFF_FFFF);
    send(REQ_SAMPLE, 32'sd0, 32'h8000_0000);
    send(REQ_SAMPLE, 32'sd0, 32'h7FFF_FFFF);
    // Full table, then appends that are dropped
    send(REQ_CLEAR, 32'sd0, 32'sd0);
    for (int i = 0; i < 66; i++) send(REQ_APPEND, i * 32'sd65536, (i % 3) * 32'sd4096);
    send(REQ_SAMPLE, 32'sd70 * 65536, 32'sd0);

    // Random paths with samples around them
    while (words_sent < ITEM_TARGET) begin
      send(REQ_CLEAR, $urandom, $urandom);
      w = $urandom_range(0, 19);
      n = (w == 0) ? $urandom_range(0, 1) : (w == 1) ? $urandom_range(60, 67)
        : $urandom_range(2, 8);
      full_range = ($urandom_range(0, 4) == 0);
      spread = full_range ? 0 : (1 << $urandom_range(4, 24));
      x = $urandom;
      y = $urandom;
      for (int i = 0; i < n; i++) begin
        if (full_range) begin
          x = $urandom;
          y = $urandom;
        end else if ($urandom_range(0, 7) != 0) begin
          x = near(x, spread);
          y = near(y, spread);
        end
        send(REQ_APPEND, x, y);
      end
      k = $urandom_range(3, 15);
      for (int i = 0; i < k; i++) begin
        w = $urandom_range(0, 19);
        if (w == 0) begin
          send(REQ_UNUSED, $urandom, $urandom);
        end else if (w == 1) begin
          send(REQ_APPEND, $urandom, $urandom);
        end else if (w == 2 || plan_len == 0 || full_range) begin
          send(REQ_SAMPLE, $urandom, $urandom);
        end else begin
          int j;
          j = $urandom_range(0, plan_len - 1);
          send(REQ_SAMPLE, near(plan_x[j], spread), near(plan_y[j], spread));
        end
      end
    end
    req_ch.valid <= 1'b0;

    // let the checker see the last accepted word before waiting on it
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS waypoint_cross_track_error_unit");
    end else begin
      $display("FAIL waypoint_cross_track_error_unit");
    end
    $finish;
  end

endmodule
`default_nettype wire
